[hdl/mm_pkg.sv]
`default_nettype none
package mm_pkg;

  // Fixed field widths
  localparam int CFG_DIM_W  = 4;
  localparam int IN_IDX_W   = 3;
  localparam int OUT_IDX_W  = 3;
  localparam int VALUE_W    = 16;
  localparam int PROD_W     = 36;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  // Parameter defaults
  localparam int MAX_DIM_DEF    = 8;
  localparam int DATA_WIDTH_DEF = 16;

  // Register indexes and reset value
  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_LEN = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;
  localparam logic [CFG_DIM_W-1:0] DIM_RESET = 4'd8;

  // Item kinds
  localparam logic [1:0] KIND_WR_A    = 2'd0;
  localparam logic [1:0] KIND_WR_B    = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  typedef struct packed {
    logic [1:0]                 kind;
    logic [IN_IDX_W-1:0]        row;
    logic [IN_IDX_W-1:0]        col;
    logic signed [VALUE_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0]       out_row;
    logic [OUT_IDX_W-1:0]       out_col;
    logic signed [PROD_W-1:0]   product;
    logic                       last;
  } out_item_t;

  // One multiply-accumulate term issued by the sequencer
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } term_ctl_t;

  // Accumulator status back to the sequencer
  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] acc;
  } mac_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } seq_state_t;

endpackage
`default_nettype wire

[hdl/mm_store.sv]
`default_nettype none
module mm_store #(
  parameter int DEPTH = mm_pkg::MAX_DIM_DEF * mm_pkg::MAX_DIM_DEF,
  parameter int WIDTH = mm_pkg::DATA_WIDTH_DEF
) (
  input  wire                          clk,
  input  wire                          wr_en,
  input  wire  [$clog2(DEPTH)-1:0]     wr_addr,
  input  wire  [WIDTH-1:0]             wr_data,
  input  wire                          rd_en,
  input  wire  [$clog2(DEPTH)-1:0]     rd_addr,
  output logic signed [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one element
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[hdl/mm_mac.sv]
`default_nettype none
module mm_mac #(
  parameter int DATA_WIDTH = mm_pkg::DATA_WIDTH_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  mm_pkg::term_ctl_t             ctl_in,
  input  wire signed [DATA_WIDTH-1:0]   a_q,
  input  wire signed [DATA_WIDTH-1:0]   b_q,
  output mm_pkg::mac_stat_t             stat
);

  localparam int MulW = 2 * DATA_WIDTH;

  mm_pkg::term_ctl_t ctl1_r, ctl2_r;
  logic signed [MulW-1:0] mul_r;
  logic signed [MulW-1:0] mul_nxt;
  logic signed [63:0] mul_ext;
  logic signed [mm_pkg::PROD_W-1:0] acc_r, acc_nxt;
  logic done_r, done_nxt;

  // Multiply the operands that the stores just returned
  assign mul_nxt = a_q * b_q;
  assign mul_ext = 64'(mul_r);

  // Start or extend the running sum, modulo the product width
  always_comb begin
    acc_nxt  = acc_r;
    done_nxt = ctl2_r.valid && ctl2_r.last;
    if (ctl2_r.valid) begin
      if (ctl2_r.first) begin
        acc_nxt = mul_ext[mm_pkg::PROD_W-1:0];
      end else begin
        acc_nxt = acc_r + mul_ext[mm_pkg::PROD_W-1:0];
      end
    end
  end

  // Control stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      done_r <= 1'b0;
    end else begin
      ctl1_r <= ctl_in;
      ctl2_r <= ctl1_r;
      done_r <= done_nxt;
    end
  end

  // Data stages
  always_ff @(posedge clk) begin
    mul_r <= mul_nxt;
    acc_r <= acc_nxt;
  end

  assign stat.done = done_r;
  assign stat.acc  = acc_r;

endmodule
`default_nettype wire

[hdl/mm_seq.sv]
`default_nettype none
module mm_seq #(
  parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
  parameter int DATA_WIDTH = mm_pkg::DATA_WIDTH_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire  [mm_pkg::CFG_DIM_W-1:0]          rows_a,
  input  wire  [mm_pkg::CFG_DIM_W-1:0]          inner_len,
  input  wire  [mm_pkg::CFG_DIM_W-1:0]          cols_b,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  mm_pkg::in_item_t                      in_data,
  output logic                                  wr_a_en,
  output logic                                  wr_b_en,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    wr_addr,
  output logic [DATA_WIDTH-1:0]                 wr_data,
  output mm_pkg::term_ctl_t                     issue,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    a_addr,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    b_addr,
  input  mm_pkg::mac_stat_t                     stat,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output mm_pkg::out_item_t                     out_data
);

  localparam int IdxW  = $clog2(MAX_DIM);
  localparam int AddrW = $clog2(MAX_DIM * MAX_DIM);
  localparam logic [AddrW-1:0] DimA = AddrW'(MAX_DIM);
  localparam logic [mm_pkg::CFG_DIM_W-1:0] DimC = mm_pkg::CFG_DIM_W'(MAX_DIM);
  localparam logic [mm_pkg::IN_IDX_W:0] DimW = (mm_pkg::IN_IDX_W + 1)'(MAX_DIM);

  mm_pkg::seq_state_t state_r, state_nxt;
  logic [IdxW-1:0] i_r, i_nxt, k_r, k_nxt, j_r, j_nxt;
  logic [IdxW-1:0] m_last, n_last, p_last;
  logic out_valid_r, out_valid_nxt;
  mm_pkg::out_item_t out_data_r, out_data_nxt;
  logic accept, in_range, out_free, entry_last;
  logic signed [31:0] value_ext;
  logic [IdxW-1:0] wr_row, wr_col;

  // Last index of a dimension, with zero used as one and the top clamped
  function automatic logic [IdxW-1:0] dim_last(input logic [mm_pkg::CFG_DIM_W-1:0] d);
    logic [mm_pkg::CFG_DIM_W-1:0] c;
    if (d == '0) begin
      c = '0;
    end else if (d > DimC) begin
      c = DimC - 1'b1;
    end else begin
      c = d - 1'b1;
    end
    return c[IdxW-1:0];
  endfunction

  assign m_last = dim_last(rows_a);
  assign n_last = dim_last(inner_len);
  assign p_last = dim_last(cols_b);

  // Input side: take beats only while idle
  assign in_stall = (state_r != mm_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_range = ({1'b0, in_data.row} < DimW) && ({1'b0, in_data.col} < DimW);

  // Element write path
  assign value_ext = 32'($signed(in_data.value));
  assign wr_data   = value_ext[DATA_WIDTH-1:0];
  assign wr_row    = IdxW'(in_data.row);
  assign wr_col    = IdxW'(in_data.col);
  assign wr_addr   = AddrW'(wr_row) * DimA + AddrW'(wr_col);

  always_comb begin
    wr_a_en = 1'b0;
    wr_b_en = 1'b0;
    if (accept && in_range) begin
      unique case (in_data.kind)
        mm_pkg::KIND_WR_A: wr_a_en = 1'b1;
        mm_pkg::KIND_WR_B: wr_b_en = 1'b1;
        default: ;
      endcase
    end
  end

  // Operand addresses for the current term
  assign a_addr = AddrW'(i_r) * DimA + AddrW'(j_r);
  assign b_addr = AddrW'(j_r) * DimA + AddrW'(k_r);

  assign out_free   = !out_valid_r || !out_stall;
  assign entry_last = (i_r == m_last) && (k_r == p_last);

  // Next state, counters and output register load
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    issue         = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      mm_pkg::ST_IDLE: begin
        if (accept && (in_data.kind == mm_pkg::KIND_COMPUTE)) begin
          i_nxt     = '0;
          k_nxt     = '0;
          j_nxt     = '0;
          state_nxt = mm_pkg::ST_RUN;
        end
      end
      mm_pkg::ST_RUN: begin
        issue.valid = 1'b1;
        issue.first = (j_r == '0);
        issue.last  = (j_r == n_last);
        if (j_r == n_last) begin
          j_nxt     = '0;
          state_nxt = mm_pkg::ST_DRAIN;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      mm_pkg::ST_DRAIN: begin
        if (stat.done) begin
          state_nxt = mm_pkg::ST_EMIT;
        end
      end
      mm_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.out_row = mm_pkg::OUT_IDX_W'(i_r);
          out_data_nxt.out_col = mm_pkg::OUT_IDX_W'(k_r);
          out_data_nxt.product = stat.acc;
          out_data_nxt.last    = entry_last;
          if (entry_last) begin
            state_nxt = mm_pkg::ST_IDLE;
          end else begin
            state_nxt = mm_pkg::ST_RUN;
            if (k_r == p_last) begin
              k_nxt = '0;
              i_nxt = i_r + 1'b1;
            end else begin
              k_nxt = k_r + 1'b1;
            end
          end
        end
      end
      default: state_nxt = mm_pkg::ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      k_r         <= '0;
      j_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[hdl/matrix_multiply_core.sv]
// Element writes (kinds 0 and 1) fill the stores and give no result.
// A compute emits M*P entries. For each one, N operand reads are issued,
// the terms pass the store read, multiply and accumulate registers, and
// the output register is loaded once out_stall allows. Input is stalled
// from compute accept until the last entry is loaded.
// Synchronous reset clears control, sets all dimensions to 8, keeps the stores.
`default_nettype none
module matrix_multiply_core #(
  parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
  parameter int DATA_WIDTH = mm_pkg::DATA_WIDTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  mm_pkg::in_item_t                  in_data,
  output logic                              out_valid,
  input  wire                               out_stall,
  output mm_pkg::out_item_t                 out_data,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [mm_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire  [mm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                              pready
);

  localparam int AddrW = $clog2(MAX_DIM * MAX_DIM);

  logic [mm_pkg::CFG_DIM_W-1:0] rows_a_r, inner_len_r, cols_b_r;
  logic [1:0] reg_idx;
  logic cfg_wr;
  logic wr_a_en, wr_b_en;
  logic [AddrW-1:0] wr_addr, a_addr, b_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic signed [DATA_WIDTH-1:0] a_q, b_q;
  mm_pkg::term_ctl_t issue;
  mm_pkg::mac_stat_t stat;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= mm_pkg::DIM_RESET;
      inner_len_r <= mm_pkg::DIM_RESET;
      cols_b_r    <= mm_pkg::DIM_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        mm_pkg::REG_ROWS_A:    rows_a_r    <= pwdata[mm_pkg::CFG_DIM_W-1:0];
        mm_pkg::REG_INNER_LEN: inner_len_r <= pwdata[mm_pkg::CFG_DIM_W-1:0];
        mm_pkg::REG_COLS_B:    cols_b_r    <= pwdata[mm_pkg::CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      mm_pkg::REG_ROWS_A:    prdata = mm_pkg::APB_DATA_W'(rows_a_r);
      mm_pkg::REG_INNER_LEN: prdata = mm_pkg::APB_DATA_W'(inner_len_r);
      mm_pkg::REG_COLS_B:    prdata = mm_pkg::APB_DATA_W'(cols_b_r);
      default:               prdata = '0;
    endcase
  end

  mm_seq #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .rows_a    (rows_a_r),
    .inner_len (inner_len_r),
    .cols_b    (cols_b_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .wr_a_en   (wr_a_en),
    .wr_b_en   (wr_b_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .issue     (issue),
    .a_addr    (a_addr),
    .b_addr    (b_addr),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  mm_store #(
    .DEPTH (MAX_DIM * MAX_DIM),
    .WIDTH (DATA_WIDTH)
  ) u_store_a (
    .clk     (clk),
    .wr_en   (wr_a_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue.valid),
    .rd_addr (a_addr),
    .rd_data (a_q)
  );

  mm_store #(
    .DEPTH (MAX_DIM * MAX_DIM),
    .WIDTH (DATA_WIDTH)
  ) u_store_b (
    .clk     (clk),
    .wr_en   (wr_b_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue.valid),
    .rd_addr (b_addr),
    .rd_data (b_q)
  );

  mm_mac #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_in (issue),
    .a_q    (a_q),
    .b_q    (b_q),
    .stat   (stat)
  );

`ifndef SYNTHESIS
  // A compute beat makes the block busy on the next cycle
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_data.kind == mm_pkg::KIND_COMPUTE)) |=> in_stall)
    else $error("compute accepted but input not stalled");

  // Store reads never overlap element writes
  a_no_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
    issue.valid |-> (in_stall && !wr_a_en && !wr_b_en))
    else $error("operand read while element writes are open");

  // A finished sum only appears during a compute
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> in_stall)
    else $error("accumulator done outside a compute");
`endif

endmodule
`default_nettype wire
